### design/hash_set_insert_erase_find_unit_assert.svh
// Assertion macros shared by the hash set RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HASH_SET_INSERT_ERASE_FIND_UNIT_ASSERT_SVH
`define HASH_SET_INSERT_ERASE_FIND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSIEF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSIEF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hsief_pkg.sv
// Shared types and constants for the hash set insert/erase/find unit.
// Depends on nothing; imported by every module of the block.
package hsief_pkg;

    localparam int KEY_W        = 32;
    localparam int ACT_W        = 2;
    localparam int BUCKETS_DEF  = 1024;
    localparam int SLOTS_DEF    = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef struct packed {
        logic was_present;
        logic bucket_full;
    } res_t;

endpackage

### design/hash_set_insert_erase_find_unit.sv
// Hash set insert/erase/find unit: input words carry an action and a signed
// 32-bit key; each word yields one result word (was_present, bucket_full).
// The key selects bucket key mod BUCKETS; each bucket holds SLOTS_PER_BUCKET keys.
// With BUCKETS a power of two, a word passes from the queue to the table engine,
// which reads its bucket row (B_IDLE) and writes it back updated (B_EVAL); the
// engine takes no new word until that read-then-write is done. With any other
// BUCKETS the front end folds the key through constant per-nibble residue
// tables (F_CALC, F_PUSH) and accepts no new word until the last is pushed.
// After reset the table clears itself, one bucket row per cycle; words are
// accepted into the queue meanwhile but not processed.
// A stalled m_ready holds the result word; up to two more words wait in the
// queue, and with BUCKETS a power of two s_ready stays high until it fills.
// Depends on hsief_pkg, hsief_front, hsief_queue and hsief_back.
module hash_set_insert_erase_find_unit
    import hsief_pkg::*;
#(
    parameter int BUCKETS          = BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ACT_W-1:0]        s_action,
    input  logic signed [KEY_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_was_present,
    output logic                    m_bucket_full
);

    localparam int ROW_W = $clog2(BUCKETS);
    localparam int QW    = ACT_W + KEY_W + ROW_W;

    logic               push_valid;
    logic               push_ready;
    logic [ACT_W-1:0]   push_action;
    logic [KEY_W-1:0]   push_key;
    logic [ROW_W-1:0]   push_row;
    logic               q_valid;
    logic               q_ready;
    logic [QW-1:0]      q_data;

    hsief_front #(
        .BUCKETS     (BUCKETS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_key       ($unsigned(s_value)),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_action (push_action),
        .push_key    (push_key),
        .push_row    (push_row)
    );

    hsief_queue #(
        .DW       (QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_action, push_key, push_row}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    hsief_back #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_action      (q_data[QW-1 -: ACT_W]),
        .q_key         (q_data[ROW_W +: KEY_W]),
        .q_row         (q_data[ROW_W-1:0]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_was_present (m_was_present),
        .m_bucket_full (m_bucket_full)
    );

endmodule

### design/hsief_front.sv
// Front end: accepts input words and computes the bucket row of each key.
// Depends on hsief_pkg; feeds hsief_queue.
module hsief_front
    import hsief_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int ROW_W  = $clog2(BUCKETS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [KEY_W-1:0]    s_key,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [ACT_W-1:0]    push_action,
    output logic [KEY_W-1:0]    push_key,
    output logic [ROW_W-1:0]    push_row
);

    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
        // Bucket is the low key bits.
        assign s_ready     = push_ready;
        assign push_valid  = s_valid;
        assign push_action = s_action;
        assign push_key    = s_key;
        assign push_row    = s_key[ROW_W-1:0];
    end else begin : g_table
        localparam int NIB   = KEY_W / 4;
        localparam int SUM_W = ROW_W + 3;
        localparam logic [SUM_W-1:0] B1 = SUM_W'(BUCKETS);
        localparam logic [SUM_W-1:0] B2 = SUM_W'(2 * BUCKETS);
        localparam logic [SUM_W-1:0] B4 = SUM_W'(4 * BUCKETS);

        typedef enum logic [2:0] {
            F_IDLE = 3'b001,
            F_CALC = 3'b010,
            F_PUSH = 3'b100
        } fstate_t;

        fstate_t           state_reg, state_next;
        logic [ACT_W-1:0]  action_reg;
        logic [KEY_W-1:0]  key_reg;
        logic [SUM_W-1:0]  sum_reg;
        logic [ROW_W-1:0]  part [NIB];
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  r4;
        logic [SUM_W-1:0]  r2;
        logic [SUM_W-1:0]  r1;

        // Residue of every nibble value at every nibble position.
        for (genvar i = 0; i < NIB; i++) begin : g_nib
            logic [ROW_W-1:0] tbl [16];
            for (genvar n = 0; n < 16; n++) begin : g_val
                localparam int unsigned POS = (16 ** i) % BUCKETS;
                localparam int unsigned RES = (n * POS) % BUCKETS;
                assign tbl[n] = ROW_W'(RES);
            end
            assign part[i] = tbl[key_reg[4*i +: 4]];
        end

        always_comb begin
            sum = '0;
            for (int i = 0; i < NIB; i++) begin
                sum = sum + SUM_W'(part[i]);
            end
        end

        // Sum is below eight times BUCKETS; strip 4B, 2B and B in turn.
        always_comb begin
            r4 = (sum_reg >= B4) ? sum_reg - B4 : sum_reg;
            r2 = (r4 >= B2) ? r4 - B2 : r4;
            r1 = (r2 >= B1) ? r2 - B1 : r2;
        end

        always_comb begin
            state_next = state_reg;
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) state_next = F_CALC;
                end
                F_CALC: begin
                    state_next = F_PUSH;
                end
                F_PUSH: begin
                    if (push_ready) state_next = F_IDLE;
                end
                default: state_next = F_IDLE;
            endcase
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                state_reg <= F_IDLE;
            end else begin
                state_reg <= state_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (state_reg == F_IDLE) begin
                action_reg <= s_action;
                key_reg    <= s_key;
            end else if (state_reg == F_CALC) begin
                sum_reg <= sum;
            end
        end

        assign s_ready     = (state_reg == F_IDLE);
        assign push_valid  = (state_reg == F_PUSH);
        assign push_action = action_reg;
        assign push_key    = key_reg;
        assign push_row    = r1[ROW_W-1:0];
    end

endmodule

### design/hsief_queue.sv
// Two-entry queue between the front end and the table engine.
// Depends on hsief_pkg for the default data width.
module hsief_queue
    import hsief_pkg::*;
#(
    parameter int DW = ACT_W + KEY_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  logic [DW-1:0] wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output logic [DW-1:0] rd_data
);

    localparam int DEPTH = 2;

    logic [DW-1:0] entry_reg [DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    assign wr_ready = (count_reg != 2'(DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### design/hsief_back.sv
// Table engine: clears the bucket memory, then reads, updates and writes one row per word.
// Depends on hsief_pkg and the assertion macro header.
`include "hash_set_insert_erase_find_unit_assert.svh"

module hsief_back
    import hsief_pkg::*;
#(
    parameter int BUCKETS          = BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_DEF,
    localparam int ROW_W           = $clog2(BUCKETS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [ACT_W-1:0]   q_action,
    input  logic [KEY_W-1:0]   q_key,
    input  logic [ROW_W-1:0]   q_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_was_present,
    output logic               m_bucket_full
);

    localparam int SL    = SLOTS_PER_BUCKET;
    localparam int LINE_W = SL * (KEY_W + 1);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EVAL  = 3'b100
    } bstate_t;

    // Row layout: valid bits in the low SL bits, then one key per slot.
    logic [LINE_W-1:0] mem [BUCKETS];

    bstate_t            state_reg, state_next;
    logic [LINE_W-1:0]  rdata_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   clr_reg;
    logic               m_valid_reg;
    res_t               res_reg, res_next;

    logic [SL-1:0]      valid_v;
    logic [SL-1:0]      hit_v;
    logic [SL-1:0]      free_oh;
    logic [SL-1:0]      new_valid;
    logic               hit;
    logic               full;
    logic               do_ins;
    logic [LINE_W-1:0]  new_line;
    logic               fire;
    logic               rd_en;
    logic               we;
    logic [ROW_W-1:0]   waddr;
    logic [LINE_W-1:0]  wdata;

    always_comb begin
        valid_v = rdata_reg[SL-1:0];
        for (int s = 0; s < SL; s++) begin
            hit_v[s] = valid_v[s] && (rdata_reg[SL + KEY_W*s +: KEY_W] == key_reg);
        end
        hit     = |hit_v;
        full    = &valid_v;
        // Lowest clear valid bit.
        free_oh = ~valid_v & (valid_v + SL'(1));
        do_ins  = (act_reg == ACT_INSERT) && !hit && !full;

        new_valid = valid_v;
        if (do_ins) begin
            new_valid = valid_v | free_oh;
        end else if (act_reg == ACT_ERASE) begin
            new_valid = valid_v & ~hit_v;
        end

        new_line = rdata_reg;
        new_line[SL-1:0] = new_valid;
        for (int s = 0; s < SL; s++) begin
            if (do_ins && free_oh[s]) new_line[SL + KEY_W*s +: KEY_W] = key_reg;
        end

        res_next.was_present = hit;
        res_next.bucket_full = (act_reg == ACT_INSERT) && !hit && full;
    end

    assign fire    = (state_reg == B_EVAL) && (!m_valid_reg || m_ready);
    assign rd_en   = (state_reg == B_IDLE) && q_valid;
    assign q_ready = rd_en;
    assign we      = (state_reg == B_CLEAR) || fire;
    assign waddr   = (state_reg == B_CLEAR) ? clr_reg : row_reg;
    assign wdata   = (state_reg == B_CLEAR) ? '0 : new_line;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) rdata_reg <= mem[q_row];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_reg == ROW_W'(BUCKETS - 1)) state_next = B_IDLE;
            end
            B_IDLE: begin
                if (q_valid) state_next = B_EVAL;
            end
            B_EVAL: begin
                if (fire) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) clr_reg <= clr_reg + ROW_W'(1);
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            act_reg <= q_action;
            key_reg <= q_key;
            row_reg <= q_row;
        end
        if (fire) res_reg <= res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_was_present = res_reg.was_present;
    assign m_bucket_full = res_reg.bucket_full;

    `HSIEF_ASSERT_IMPL(a_full_only_new_insert, aclk, aresetn, fire && res_next.bucket_full, (act_reg == ACT_INSERT) && !res_next.was_present, "bucket_full on a non-insert or a hit")
    `HSIEF_ASSERT_IMPL(a_no_read_write_clash, aclk, aresetn, we, !rd_en, "row read and write in the same cycle")
    `HSIEF_ASSERT_NEXT(a_stall_holds_row, aclk, aresetn, (state_reg == B_EVAL) && !fire, $stable(rdata_reg) && $stable(key_reg), "row data changed while the result stalled")
    `HSIEF_ASSERT_IMPL(a_single_hit, aclk, aresetn, state_reg == B_EVAL, $onehot0(hit_v), "key stored in more than one slot")

endmodule
